// ----- design/mal_pkg.sv -----
// Shared types and constants for the MAC arrival log.
// No dependencies; used by every module of the block.
package mal_pkg;

    localparam int MAC_W  = 48;
    localparam int IFC_W  = 8;
    localparam int TIME_W = 32;
    localparam int TTL_W  = 16;
    localparam int CNT_W  = 7;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_DUMP   = 2'd3
    } opcode_t;

    // One stored log entry, as held in the entry memory.
    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [IFC_W-1:0]  ifc;
        logic [TIME_W-1:0] arrival;
    } entry_t;

endpackage

// ----- design/mal_store.sv -----
// Entry memory of the MAC arrival log: one write port, one registered read port.
// Depends on mal_pkg for the entry type.
module mal_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  mal_pkg::entry_t     wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output mal_pkg::entry_t     rd_data
);

    mal_pkg::entry_t mem [DEPTH];
    mal_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/mal_age_unit.sv -----
// Age compare unit: subtract arrival time from current time and test against TTL.
// Depends on mal_pkg for field widths.
module mal_age_unit (
    input  logic [mal_pkg::TIME_W-1:0] now_time,
    input  logic [mal_pkg::TIME_W-1:0] arrival_time,
    input  logic [mal_pkg::TTL_W-1:0]  ttl,
    output logic                       expired
);

    logic [mal_pkg::TIME_W-1:0] age;

    // Wraps modulo 2^32, so time running backwards reads as very old.
    assign age     = now_time - arrival_time;
    assign expired = age > {{(mal_pkg::TIME_W - mal_pkg::TTL_W){1'b0}}, ttl};

endmodule

// ----- design/mac_arrival_log_fifo_with_aging.sv -----
// MAC arrival log with aging: bounded FIFO of (MAC, interface, arrival time).
// Depends on mal_pkg, mal_store and mal_age_unit.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction: opcode plus
//   src_mac, interface_id, now_seconds and remove_count. in_ready is high
//   only while the sequencer is idle; one transaction is worked at a time.
//   Output channel (out_valid/out_ready) carries result transactions from a
//   single output register, so a new input is taken while a result waits.
//   Record, remove and tick give one result each; dump gives one result per
//   stored entry (oldest first), or one empty result when the log is empty.
//   cfg_wr_en/cfg_wr_data write ttl_seconds; write it only while idle.
// Sequencing: record passes S_REC then S_RESULT; remove stays in S_RMV
//   while it drops entries, then S_RESULT; tick alternates S_TICK_RD and
//   S_TICK_CMP per examined entry; dump alternates S_DUMP_RD and S_DUMP_OUT.
//   The entry memory has one registered read port, so every tick examination
//   and every dumped entry takes a read state and then a use state through the
//   shared age compare unit or output register.
// Reset: the log empties, TTL goes to zero; the memory is not cleared since
//   only written slots are ever used.
// Stall: while a result waits and out_ready is low the sequencer holds in its
//   emit state and the output register holds its transaction.
module mac_arrival_log_fifo_with_aging #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mal_pkg::TTL_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [mal_pkg::MAC_W-1:0]     src_mac,
    input  logic [mal_pkg::IFC_W-1:0]     interface_id,
    input  logic [mal_pkg::TIME_W-1:0]    now_seconds,
    input  logic [mal_pkg::CNT_W-1:0]     remove_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          entry_valid,
    output logic [mal_pkg::MAC_W-1:0]     mac_out,
    output logic [mal_pkg::IFC_W-1:0]     interface_out,
    output logic [mal_pkg::CNT_W-1:0]     entries_held,
    output logic [mal_pkg::CNT_W-1:0]     removed_now,
    output logic                          evicted_oldest,
    output logic                          last_of_run
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC,
        S_RMV,
        S_TICK_RD,
        S_TICK_CMP,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESULT
    } state_t;

    // Sequencer and log pointers
    state_t                     state_reg,      state_next;
    logic [AW-1:0]              oldest_reg,     oldest_next;
    logic [AW-1:0]              tail_reg,       tail_next;
    logic [CW-1:0]              count_reg,      count_next;
    logic [CW-1:0]              removed_reg,    removed_next;
    logic                       evicted_reg,    evicted_next;
    logic [mal_pkg::CNT_W-1:0]  rem_left_reg,   rem_left_next;
    logic [AW-1:0]              walk_ptr_reg,   walk_ptr_next;
    logic [CW-1:0]              walk_idx_reg,   walk_idx_next;
    logic [mal_pkg::TTL_W-1:0]  ttl_reg;

    // Output register
    logic                       out_valid_reg,  out_valid_next;
    logic                       entry_reg,      entry_next;
    logic [mal_pkg::MAC_W-1:0]  mac_reg,        mac_next;
    logic [mal_pkg::IFC_W-1:0]  ifc_reg,        ifc_next;
    logic [mal_pkg::CNT_W-1:0]  held_reg,       held_next;
    logic [mal_pkg::CNT_W-1:0]  rm_out_reg,     rm_out_next;
    logic                       ev_out_reg,     ev_out_next;
    logic                       last_reg,       last_next;

    // Latched input transaction
    logic [mal_pkg::MAC_W-1:0]  in_mac_reg;
    logic [mal_pkg::IFC_W-1:0]  in_ifc_reg;
    logic [mal_pkg::TIME_W-1:0] in_now_reg;

    logic                       mem_wr_en;
    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    mal_pkg::entry_t            mem_wr_data;
    mal_pkg::entry_t            mem_rd_data;
    logic                       expired;
    logic                       out_free;
    logic                       dump_last;
    logic                       full;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    mal_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (tail_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    mal_age_unit u_age (
        .now_time     (in_now_reg),
        .arrival_time (mem_rd_data.arrival),
        .ttl          (ttl_reg),
        .expired      (expired)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign out_free    = !out_valid_reg || out_ready;
    assign full        = (count_reg == CW'(DEPTH));
    assign dump_last   = ((walk_idx_reg + 1'b1) == count_reg);

    assign mem_wr_en   = (state_reg == S_REC);
    assign mem_wr_data = '{mac: in_mac_reg, ifc: in_ifc_reg, arrival: in_now_reg};
    assign mem_rd_en   = (state_reg == S_TICK_RD) || (state_reg == S_DUMP_RD);
    assign mem_rd_addr = (state_reg == S_TICK_RD) ? oldest_reg : walk_ptr_reg;

    always_comb
    begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        removed_next   = removed_reg;
        evicted_next   = evicted_reg;
        rem_left_next  = rem_left_reg;
        walk_ptr_next  = walk_ptr_reg;
        walk_idx_next  = walk_idx_reg;
        // Drop the output transaction once taken
        out_valid_next = out_valid_reg && !out_ready;
        entry_next     = entry_reg;
        mac_next       = mac_reg;
        ifc_next       = ifc_reg;
        held_next      = held_reg;
        rm_out_next    = rm_out_reg;
        ev_out_next    = ev_out_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    removed_next  = '0;
                    evicted_next  = 1'b0;
                    rem_left_next = remove_count;
                    walk_ptr_next = oldest_reg;
                    walk_idx_next = '0;
                    unique case (mal_pkg::opcode_t'(opcode))
                        mal_pkg::OP_RECORD: state_next = S_REC;
                        mal_pkg::OP_REMOVE: state_next = S_RMV;
                        mal_pkg::OP_TICK:   state_next = S_TICK_RD;
                        mal_pkg::OP_DUMP:   state_next = (count_reg == '0) ? S_RESULT
                                                                           : S_DUMP_RD;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end

            S_REC:
            begin
                // Full log: evict the oldest, the new entry takes its place in count
                if (full)
                begin
                    oldest_next  = ptr_inc(oldest_reg);
                    evicted_next = 1'b1;
                    removed_next = CW'(1);
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
                tail_next  = ptr_inc(tail_reg);
                state_next = S_RESULT;
            end

            S_RMV:
            begin
                // Drop one oldest entry a cycle until the request or the log runs out
                if ((rem_left_reg != '0) && (count_reg != '0))
                begin
                    oldest_next   = ptr_inc(oldest_reg);
                    count_next    = count_reg - 1'b1;
                    removed_next  = removed_reg + 1'b1;
                    rem_left_next = rem_left_reg - 1'b1;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_TICK_RD:
            begin
                state_next = (count_reg == '0) ? S_RESULT : S_TICK_CMP;
            end

            S_TICK_CMP:
            begin
                // Stop at the first entry still within its TTL
                if (expired)
                begin
                    oldest_next  = ptr_inc(oldest_reg);
                    count_next   = count_reg - 1'b1;
                    removed_next = removed_reg + 1'b1;
                    state_next   = S_TICK_RD;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    entry_next     = 1'b1;
                    mac_next       = mem_rd_data.mac;
                    ifc_next       = mem_rd_data.ifc;
                    held_next      = mal_pkg::CNT_W'(count_reg);
                    rm_out_next    = '0;
                    ev_out_next    = 1'b0;
                    last_next      = dump_last;
                    walk_ptr_next  = ptr_inc(walk_ptr_reg);
                    walk_idx_next  = walk_idx_reg + 1'b1;
                    state_next     = dump_last ? S_IDLE : S_DUMP_RD;
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    entry_next     = 1'b0;
                    mac_next       = '0;
                    ifc_next       = '0;
                    held_next      = mal_pkg::CNT_W'(count_reg);
                    rm_out_next    = mal_pkg::CNT_W'(removed_reg);
                    ev_out_next    = evicted_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            removed_reg   <= '0;
            evicted_reg   <= 1'b0;
            rem_left_reg  <= '0;
            walk_ptr_reg  <= '0;
            walk_idx_reg  <= '0;
            ttl_reg       <= '0;
            out_valid_reg <= 1'b0;
            entry_reg     <= 1'b0;
            mac_reg       <= '0;
            ifc_reg       <= '0;
            held_reg      <= '0;
            rm_out_reg    <= '0;
            ev_out_reg    <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            removed_reg   <= removed_next;
            evicted_reg   <= evicted_next;
            rem_left_reg  <= rem_left_next;
            walk_ptr_reg  <= walk_ptr_next;
            walk_idx_reg  <= walk_idx_next;
            if (cfg_wr_en)
            begin
                ttl_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
            entry_reg     <= entry_next;
            mac_reg       <= mac_next;
            ifc_reg       <= ifc_next;
            held_reg      <= held_next;
            rm_out_reg    <= rm_out_next;
            ev_out_reg    <= ev_out_next;
            last_reg      <= last_next;
        end
    end

    // Hold the accepted transaction's payload for the whole run
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_mac_reg <= src_mac;
            in_ifc_reg <= interface_id;
            in_now_reg <= now_seconds;
        end
    end

    assign out_valid      = out_valid_reg;
    assign entry_valid    = entry_reg;
    assign mac_out        = mac_reg;
    assign interface_out  = ifc_reg;
    assign entries_held   = held_reg;
    assign removed_now    = rm_out_reg;
    assign evicted_oldest = ev_out_reg;
    assign last_of_run    = last_reg;

endmodule

// ----- design/mal_port_checker.sv -----
// Port-level checks for the MAC arrival log, bound to the top level.
// Depends on mal_pkg for field widths and on the top level's port names.
module mal_port_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          entry_valid,
    input logic [mal_pkg::MAC_W-1:0]     mac_out,
    input logic [mal_pkg::IFC_W-1:0]     interface_out,
    input logic [mal_pkg::CNT_W-1:0]     removed_now,
    input logic                          evicted_oldest,
    input logic                          last_of_run
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mac_out) && $stable(last_of_run))
        else $error("stalled result transaction changed");

    // The sequencer is busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // Only dumped entries carry data; everything else ends its run
    a_nonentry_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_valid |-> last_of_run && mac_out == '0 && interface_out == '0)
        else $error("non-entry result not final or carries data");

    // Eviction counts as exactly one removal, never in a dump result
    a_evict_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted_oldest |-> removed_now == mal_pkg::CNT_W'(1) && !entry_valid)
        else $error("eviction result malformed");

endmodule

bind mac_arrival_log_fifo_with_aging mal_port_checker u_port_checker (.*);
